// ===== hdl/tspes_pkg.sv =====
// Package for the transport-stream PES reassembler: packet geometry,
// header byte positions, result beat types and the take-size helper.
// No dependencies.
package tspes_pkg;

    localparam int PACKET_BYTES  = 188;
    localparam int PAYLOAD_BYTES = 184;

    // PES header bytes emitted together from an opening packet (bytes 4..9)
    localparam int HDR_BYTES  = 6;
    // header bytes held in registers (bytes 4..8; byte 9 is used as it arrives)
    localparam int HOLD_BYTES = HDR_BYTES - 1;

    localparam int POS_W   = 8;
    localparam int LEFT_W  = 17;
    localparam int TAKE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;

    localparam logic [POS_W-1:0] POS_HDR_FIRST  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_START_LAST = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(9);
    localparam logic [POS_W-1:0] POS_PKT_LAST   = POS_W'(PACKET_BYTES - 1);

    // hold slots for the start code, stream id and length high byte
    localparam int HOLD_SC0     = 0;
    localparam int HOLD_SC1     = 1;
    localparam int HOLD_SID     = 3;
    localparam int HOLD_LEN_HI  = 4;

    localparam logic [BYTE_W-1:0] START_LAST_BYTE = 8'h01;

    // output queue
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_W     = $clog2(HDR_BYTES + 1);

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [BYTE_W-1:0]  stream_id;
        logic [COUNT_W-1:0] total_length;
    } pes_beat_t;

    typedef struct packed {
        logic [PUSH_W-1:0]               count;
        pes_beat_t [HDR_BYTES-1:0]       beats;
    } tspes_push_t;

    function automatic logic [TAKE_W-1:0] take_for(input logic [LEFT_W-1:0] left);
        if (left < LEFT_W'(PAYLOAD_BYTES))
            return left[TAKE_W-1:0];
        else
            return TAKE_W'(PAYLOAD_BYTES);
    endfunction

endpackage

// ===== hdl/ts_pes_reassembler_core.sv =====
// An accepted byte is decoded in the next cycle; its beats are registered into
// the output queue, read by the pes side. Throughput: one transport-stream byte
// per cycle while ts_stall is low; the six header beats of an opening packet
// drain one per cycle while pes_stall is low, through a 32-beat output queue,
// and ts_stall rises only when that queue holds more than 20 beats.
// Reset clears position, PES and queue state; held header bytes are not reset.
module ts_pes_reassembler_core
    import tspes_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // transport-stream side
    input  logic                ts_valid,
    output logic                ts_stall,
    input  logic [BYTE_W-1:0]   ts_byte,
    // reassembled PES side
    output logic                pes_valid,
    input  logic                pes_stall,
    output logic [BYTE_W-1:0]   pes_byte,
    output logic                pes_end,
    output logic [BYTE_W-1:0]   pes_stream_id,
    output logic [COUNT_W-1:0]  pes_total_length
);

    // input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    // reassembly state
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic [LEFT_W-1:0]   left_reg,     left_next;
    logic [TAKE_W-1:0]   take_reg,     take_next;
    logic                opening_reg,  opening_next;
    logic [BYTE_W-1:0]   sid_reg,      sid_next;
    logic [COUNT_W-1:0]  count_reg,    count_next;
    logic [BYTE_W-1:0]   hold_reg [0:HOLD_BYTES-1];
    logic [HOLD_BYTES-1:0] hold_we;

    logic [LEFT_W-1:0]   pes_len;
    tspes_push_t         push;
    pes_beat_t           head;
    logic [FIFO_CW-1:0]  fifo_count;
    logic                fifo_not_empty;
    logic                accept;

    // Hold the queue far enough from full that the byte in the input
    // register and the one arriving now can each push a full header burst.
    assign ts_stall = (fifo_count > FIFO_CW'(FIFO_DEPTH - 2 * HDR_BYTES));
    assign accept   = ts_valid && !ts_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= ts_byte;
    end

    // Decode one byte: packet position, start-code search, header burst and
    // payload pass-through, all in one pass.
    always_comb
    begin
        pos_next     = pos_reg;
        left_next    = left_reg;
        take_next    = take_reg;
        opening_next = opening_reg;
        sid_next     = sid_reg;
        count_next   = count_reg;
        hold_we      = '0;
        pes_len      = '0;
        push         = '0;

        if (in_valid_reg)
        begin
            // packet start: either continue the open PES or hunt for a new one
            if (pos_reg == '0)
            begin
                if (left_reg != '0)
                begin
                    opening_next = 1'b0;
                    take_next    = take_for(left_reg);
                end
                else
                begin
                    opening_next = 1'b1;
                    take_next    = '0;
                end
            end

            if (opening_next)
            begin
                for (int i = 0; i < HOLD_BYTES; i++)
                begin
                    if (pos_reg == POS_HDR_FIRST + POS_W'(i))
                        hold_we[i] = 1'b1;
                end

                if (pos_reg == POS_START_LAST)
                begin
                    // drop the packet unless bytes 4..6 are 00 00 01
                    if (hold_reg[HOLD_SC0] != '0 || hold_reg[HOLD_SC1] != '0
                        || in_byte_reg != START_LAST_BYTE)
                        opening_next = 1'b0;
                end
                else if (pos_reg == POS_LEN_LO)
                begin
                    pes_len      = {1'b0, hold_reg[HOLD_LEN_HI], in_byte_reg}
                                   + LEFT_W'(HDR_BYTES);
                    opening_next = 1'b0;
                    left_next    = pes_len - LEFT_W'(HDR_BYTES);
                    sid_next     = hold_reg[HOLD_SID];
                    count_next   = COUNT_W'(HDR_BYTES);
                    take_next    = take_for(pes_len) - TAKE_W'(HDR_BYTES);

                    // header burst: only its final beat can close the PES
                    push.count = PUSH_W'(HDR_BYTES);
                    for (int i = 0; i < HOLD_BYTES; i++)
                        push.beats[i].data = hold_reg[i];
                    push.beats[HDR_BYTES-1].data = in_byte_reg;
                    if (pes_len == LEFT_W'(HDR_BYTES))
                    begin
                        push.beats[HDR_BYTES-1].last         = 1'b1;
                        push.beats[HDR_BYTES-1].stream_id    = hold_reg[HOLD_SID];
                        push.beats[HDR_BYTES-1].total_length = COUNT_W'(HDR_BYTES);
                    end
                end
            end
            else if (pos_reg >= POS_HDR_FIRST && take_next != '0 && left_reg != '0)
            begin
                take_next  = take_next - TAKE_W'(1);
                left_next  = left_reg - LEFT_W'(1);
                count_next = count_reg + COUNT_W'(1);

                push.count         = PUSH_W'(1);
                push.beats[0].data = in_byte_reg;
                if (left_next == '0)
                begin
                    push.beats[0].last         = 1'b1;
                    push.beats[0].stream_id    = sid_reg;
                    push.beats[0].total_length = count_next;
                end
            end

            // advance the packet position, wrapping at the packet end
            pos_next = (pos_reg == POS_PKT_LAST) ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            left_reg    <= '0;
            take_reg    <= '0;
            opening_reg <= 1'b0;
            sid_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            left_reg    <= left_next;
            take_reg    <= take_next;
            opening_reg <= opening_next;
            sid_reg     <= sid_next;
            count_reg   <= count_next;
        end
    end

    // header bytes 4..8 of a candidate packet
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HOLD_BYTES; i++)
        begin
            if (hold_we[i])
                hold_reg[i] <= in_byte_reg;
        end
    end

    tspes_beat_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (!pes_stall),
        .not_empty (fifo_not_empty),
        .head      (head),
        .count     (fifo_count)
    );

    assign pes_valid        = fifo_not_empty;
    assign pes_byte         = head.data;
    assign pes_end          = head.last;
    assign pes_stream_id    = head.stream_id;
    assign pes_total_length = head.total_length;

    // the queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overfilled");

    // a byte in the input register always finds room for a full header burst
    a_room_for_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> fifo_count <= FIFO_CW'(FIFO_DEPTH - HDR_BYTES))
        else $error("input byte taken without queue room");

    // a start-code hunt only runs while no PES is open
    a_hunt_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        opening_reg |-> left_reg == '0)
        else $error("start-code search while a PES is open");

    // end-only fields stay zero on inner beats
    a_inner_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pes_valid && !pes_end) |-> (pes_stream_id == '0 && pes_total_length == '0))
        else $error("stream id or length set on an inner beat");

endmodule

// ===== hdl/tspes_beat_fifo.sv =====
// Result queue of the PES reassembler: takes up to six beats per cycle,
// delivers one per cycle while pop is high. Depends on tspes_pkg.
module tspes_beat_fifo
    import tspes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tspes_push_t        push,
    input  logic               pop,
    output logic               not_empty,
    output pes_beat_t          head,
    output logic [FIFO_CW-1:0] count
);

    pes_beat_t            mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && not_empty;

    // storage: write the pushed beats at consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            if (PUSH_W'(i) < push.count)
                mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= push.beats[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_reg + FIFO_CW'(push.count) - FIFO_CW'(do_pop);
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench for ts_pes_reassembler_core: aligned 188-byte transport packets
// are fed one byte per beat, and every PES beat is checked against a predictor.
// Depends on tspes_pkg (hdl/tspes_pkg.sv) and the core RTL only.
module testbench
    import tspes_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // bytes sent of the final, unfinished packet
    localparam int TAIL_BYTES = 34;

    // ------------------------------------------------------------------
    // Predictor and store of awaited PES beats.
    // note_ts_byte() advances the predicted reassembly state by one
    // accepted transport byte and queues the beats it should release;
    // check_pes_beat() compares a delivered beat with the oldest of them.
    // ------------------------------------------------------------------
    class pes_tracker;
        pes_beat_t          awaited_beats[$];
        int                 mismatches;
        logic [POS_W-1:0]   pos;
        logic [LEFT_W-1:0]  left;
        logic [TAKE_W-1:0]  take_left;
        bit                 opening;
        logic [BYTE_W-1:0]  hdr [HDR_BYTES];
        logic [BYTE_W-1:0]  sid;
        logic [COUNT_W-1:0] count;

        function new();
            pos       = '0;
            left      = '0;
            take_left = '0;
            opening   = 1'b0;
            sid       = '0;
            count     = '0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function int beats_awaited();
            return awaited_beats.size();
        endfunction

        // one PES byte leaves the block; the last one carries id and length
        function void append_beat(logic [BYTE_W-1:0] b);
            pes_beat_t beat;
            count = count + 16'd1;
            if (left != 0)
                left = left - 17'd1;
            beat.data = b;
            if (left == 0) begin
                beat.last         = 1'b1;
                beat.stream_id    = sid;
                beat.total_length = count;
            end
            else begin
                beat.last         = 1'b0;
                beat.stream_id    = '0;
                beat.total_length = '0;
            end
            awaited_beats.push_back(beat);
        endfunction

        function void note_ts_byte(logic [BYTE_W-1:0] b);
            logic [POS_W-1:0]  p;
            logic [LEFT_W-1:0] pes_len;
            p = pos;
            // a new packet either continues the open PES or hunts for a start
            if (p == 0) begin
                if (left != 0) begin
                    opening   = 1'b0;
                    take_left = (left < PAYLOAD_BYTES) ? left[TAKE_W-1:0]
                                                       : TAKE_W'(PAYLOAD_BYTES);
                end
                else begin
                    opening   = 1'b1;
                    take_left = '0;
                end
            end
            if (opening) begin
                if (p >= POS_HDR_FIRST && p <= POS_LEN_LO)
                    hdr[int'(p) - int'(POS_HDR_FIRST)] = b;
                if (p == POS_START_LAST) begin
                    if (hdr[HOLD_SC0] != 0 || hdr[HOLD_SC1] != 0 || b != START_LAST_BYTE)
                        opening = 1'b0;
                end
                else if (p == POS_LEN_LO) begin
                    pes_len   = {1'b0, hdr[HOLD_LEN_HI], b} + LEFT_W'(HDR_BYTES);
                    opening   = 1'b0;
                    left      = pes_len;
                    sid       = hdr[HOLD_SID];
                    count     = '0;
                    take_left = ((pes_len < PAYLOAD_BYTES) ? pes_len[TAKE_W-1:0]
                                                           : TAKE_W'(PAYLOAD_BYTES))
                                - TAKE_W'(HDR_BYTES);
                    for (int i = 0; i < HDR_BYTES; i++)
                        append_beat(hdr[i]);
                end
            end
            else if (p >= POS_HDR_FIRST && take_left != 0 && left != 0) begin
                take_left = take_left - 8'd1;
                append_beat(b);
            end
            pos = (int'(p) + 1 >= PACKET_BYTES) ? '0 : p + 8'd1;
        endfunction

        task report(string what);
            $display("%0t ns: PES mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_pes_beat(pes_beat_t got);
            pes_beat_t want;
            if (awaited_beats.size() == 0) begin
                report($sformatf("beat %02h arrived with nothing awaited", got.data));
                return;
            end
            want = awaited_beats.pop_front();
            if (got.data !== want.data)
                report($sformatf("pes_byte %02h, want %02h", got.data, want.data));
            if (got.last !== want.last)
                report($sformatf("pes_end %b, want %b", got.last, want.last));
            if (got.stream_id !== want.stream_id)
                report($sformatf("pes_stream_id %02h, want %02h",
                                 got.stream_id, want.stream_id));
            if (got.total_length !== want.total_length)
                report($sformatf("pes_total_length %0d, want %0d",
                                 got.total_length, want.total_length));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n     = 1'b0;
    logic                ts_valid  = 1'b0;
    logic                ts_stall;
    logic [BYTE_W-1:0]   ts_byte   = '0;
    logic                pes_valid;
    logic                pes_stall = 1'b0;
    logic [BYTE_W-1:0]   pes_byte;
    logic                pes_end;
    logic [BYTE_W-1:0]   pes_stream_id;
    logic [COUNT_W-1:0]  pes_total_length;

    logic [BYTE_W-1:0]   ts_packet [PACKET_BYTES];
    pes_tracker          tracker;

    ts_pes_reassembler_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .ts_valid         (ts_valid),
        .ts_stall         (ts_stall),
        .ts_byte          (ts_byte),
        .pes_valid        (pes_valid),
        .pes_stall        (pes_stall),
        .pes_byte         (pes_byte),
        .pes_end          (pes_end),
        .pes_stream_id    (pes_stream_id),
        .pes_total_length (pes_total_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Transport side. All drives happen just after a rising edge, so the
    // block sees them at the next one. Valid stays high between beats
    // unless a gap is drawn, and is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0)
        begin
            ts_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ts_valid <= 1'b1;
        ts_byte  <= b;
        // hold the beat until an edge sees it with stall low
        do @(posedge clk); while (ts_stall !== 1'b0);
        tracker.note_ts_byte(b);
    endtask

    task automatic fill_packet();
        foreach (ts_packet[i])
            ts_packet[i] = BYTE_W'($urandom);
    endtask

    // send the first nbytes bytes of the prepared packet
    task automatic send_packet(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(ts_packet[i]);
    endtask

    // put the start code 00 00 01 at bytes 4..6 of the prepared packet
    task automatic plant_start_code();
        ts_packet[4] = 8'h00;
        ts_packet[5] = 8'h00;
        ts_packet[6] = START_LAST_BYTE;
    endtask

    // prepare an opening packet with the start code, stream id and length
    task automatic fill_opening(input logic [BYTE_W-1:0] stream_id,
                                input logic [15:0] len_field);
        fill_packet();
        plant_start_code();
        ts_packet[7] = stream_id;
        ts_packet[8] = len_field[15:8];
        ts_packet[9] = len_field[7:0];
    endtask

    // Send one well-formed PES: an opening packet with the start code and
    // length, then as many continuation packets as the length needs. With
    // code_in_payload set, continuation packets carry a fake start code
    // that must be passed through as plain data.
    task automatic send_pes(input logic [BYTE_W-1:0] stream_id,
                            input logic [15:0] len_field,
                            input bit code_in_payload);
        int unsigned remaining;
        fill_opening(stream_id, len_field);
        send_packet(PACKET_BYTES);
        remaining = len_field + HDR_BYTES;
        remaining -= (remaining < PAYLOAD_BYTES) ? remaining : PAYLOAD_BYTES;
        while (remaining > 0)
        begin
            fill_packet();
            if (code_in_payload)
                plant_start_code();
            send_packet(PACKET_BYTES);
            remaining -= (remaining < PAYLOAD_BYTES) ? remaining : PAYLOAD_BYTES;
        end
    endtask

    // Send a packet whose start code is spoilt at one of its three bytes;
    // while no PES is open the whole packet must be skipped.
    task automatic send_broken(input int slot);
        fill_packet();
        plant_start_code();
        if (slot < 2)
            ts_packet[4 + slot] = BYTE_W'($urandom_range(1, 255));
        else
            ts_packet[6] = BYTE_W'($urandom_range(0, 254) + 2);
        send_packet(PACKET_BYTES);
    endtask

    // Hold the sender off until every awaited beat has been delivered.
    task automatic wait_for_pes_drain();
        ts_valid <= 1'b0;
        @(posedge clk);
        while (tracker.beats_awaited() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // PES side: draw a stall length for each beat, then take the next one
    // offered and check it. Stalls thus fall on every phase of the burst.
    // ------------------------------------------------------------------
    initial
    begin : pes_sink
        int hold;
        pes_beat_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(0, 9);
            if (hold != 0)
            begin
                pes_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            pes_stall <= 1'b0;
            do @(posedge clk); while (pes_valid !== 1'b1);
            got.data         = pes_byte;
            got.last         = pes_end;
            got.stream_id    = pes_stream_id;
            got.total_length = pes_total_length;
            tracker.check_pes_beat(got);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: two full packets and the head of a third, about 410 beats.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [15:0] len_field;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first packet: either a spoilt start code, so the packet is skipped,
        // or a zero length field, so the PES is just the six header beats
        // and the rest of the packet is dropped
        if ($urandom_range(0, 1) == 0)
            send_broken(int'($urandom_range(0, 2)));
        else
            send_pes(8'hC0, 16'd0, 1'b0);

        // opening packet whose PES spills 1..20 bytes into the next packet
        len_field = 16'($urandom_range(179, 198));
        fill_opening(BYTE_W'($urandom), len_field);
        send_packet(PACKET_BYTES);
        // let the whole opening packet drain before going on
        wait_for_pes_drain();

        // continuation packet with a fake start code as data; the PES closes
        // inside it and the remaining bytes are dropped
        fill_packet();
        plant_start_code();
        send_packet(TAIL_BYTES);

        // everything sent: wait for the last beats, then a little longer in
        // case anything stray follows
        wait_for_pes_drain();
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin : watchdog
        #2ms;
        $display("Timeout with %0d PES beats still awaited", tracker.beats_awaited());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tspes_pkg.sv
hdl/tspes_beat_fifo.sv
hdl/ts_pes_reassembler_core.sv
sim/testbench.sv
